// ===== hdl/seven_segment_serial_driver_defines.svh =====
// assertion macros for the seven-segment serial driver
// each macro expects signals named clock and reset in the using module
`ifndef SEVEN_SEGMENT_SERIAL_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_SERIAL_DRIVER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SSD_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SSD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ssd_pkg.sv =====
// shared types, codes and segment tables for the seven-segment serial driver
// no dependencies
package ssd_pkg;

   localparam logic [1:0]  OP_NUMBER      = 2'd0;
   localparam logic [1:0]  OP_CHARACTER   = 2'd1;
   localparam logic [1:0]  OP_BLANK       = 2'd2;
   localparam logic [13:0] NUMBER_MAX     = 14'd9999;
   localparam logic [7:0]  BLANK_SEGMENTS = 8'hFF;
   localparam int          FRAME_BITS     = 16;
   localparam int          QUEUE_DEPTH    = 4;
   localparam int          BIN_BITS       = 14;

   typedef struct packed {
      logic                  valid;
      logic [FRAME_BITS-1:0] frame;
      logic                  last;
   } ssd_entry_type;

   function automatic logic [7:0] digit_segments(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         default: s = BLANK_SEGMENTS;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] select_pattern(input logic [1:0] pos);
      logic [7:0] s;
      case (pos)
         2'd0:    s = 8'hF1;
         2'd1:    s = 8'hF2;
         2'd2:    s = 8'hF4;
         default: s = 8'hF8;
      endcase
      return s;
   endfunction

   // letters in either case, anything else blanks
   function automatic logic [7:0] letter_segments(input logic [7:0] ch);
      logic [7:0] c;
      logic [4:0] idx;
      logic [7:0] s;
      c = ch;
      if (c >= 8'h61 && c <= 8'h7A) begin
         c = c - 8'd32;
      end
      idx = 5'(c - 8'h41);
      if (c >= 8'h41 && c <= 8'h5A) begin
         case (idx)
            5'd0:    s = 8'h88;
            5'd1:    s = 8'h83;
            5'd2:    s = 8'hC6;
            5'd3:    s = 8'hA1;
            5'd4:    s = 8'h86;
            5'd5:    s = 8'h8E;
            5'd6:    s = 8'hC2;
            5'd7:    s = 8'h89;
            5'd8:    s = 8'hCF;
            5'd9:    s = 8'hE1;
            5'd10:   s = 8'h8A;
            5'd11:   s = 8'hC7;
            5'd12:   s = 8'hEA;
            5'd13:   s = 8'hC8;
            5'd14:   s = 8'hC0;
            5'd15:   s = 8'h8C;
            5'd16:   s = 8'h4A;
            5'd17:   s = 8'hCC;
            5'd18:   s = 8'h92;
            5'd19:   s = 8'h87;
            5'd20:   s = 8'hC1;
            5'd21:   s = 8'hC1;
            5'd22:   s = 8'hD5;
            5'd23:   s = 8'h89;
            5'd24:   s = 8'h91;
            5'd25:   s = 8'hA4;
            default: s = BLANK_SEGMENTS;
         endcase
      end else begin
         s = BLANK_SEGMENTS;
      end
      return s;
   endfunction

endpackage

// ===== hdl/seven_segment_serial_driver.sv =====
// seven-segment serial driver: request channel in, one serial bit per result beat
// A request beat on req_* carries operation, number_value, character_code and
// digit_position. A number from 0 to 9999 gives four 16-bit frames (thousands
// digit first), a character or blank gives one frame, and out-of-range requests
// give nothing. Each frame leaves on rsp_* as 16 beats, segment byte then
// digit-select byte, msb first; rsp_tuser marks the bit after which the latch
// pulses and rsp_tlast marks the final bit of the request.
// A character passes through the frame queue and the shifter register before its
// first output beat; a number first goes through bcd conversion and the push
// state in the decoder. The shifter sends one bit per cycle while rsp_tready is
// high, with no gap between frames when the next frame is queued; the shifter is
// the limit on sustained rate.
// A four-entry frame queue separates decoder and shifter: the decoder takes new
// requests while the shifter is busy, and req_tready drops while the queue is
// full or a number is being converted and pushed.
// When rsp_tready is low the current bit holds and the queue fills behind it.
// Synchronous reset empties the queue and idles both sides.
module seven_segment_serial_driver #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // operation[1:0], number_value[15:2],
                                   // character_code[23:16], digit_position[25:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // serial_bit[0]
   output logic        rsp_tuser,  // latch_after[0]
   output logic        rsp_tlast
);
   import ssd_pkg::*;

   ssd_entry_type push;
   ssd_entry_type head;
   logic          queue_full;
   logic          pop;

   ssd_front #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push)
   );

   ssd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   ssd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/ssd_front.sv =====
// request decoder: classifies items, splits numbers into bcd digits, pushes frames
// depends on ssd_pkg
module ssd_front #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,  // operation, number_value, character_code,
                                             // digit_position, zero pad
   input  logic                  queue_full,
   output ssd_pkg::ssd_entry_type push
);
   import ssd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_CONVERT = 3'b010,
      ST_PUSH    = 3'b100
   } state_type;

   localparam logic [1:0] LAST_IDX  = 2'(DIGIT_COUNT - 1);
   localparam logic [3:0] LAST_STEP = 4'(BIN_BITS - 1);

   state_type  state_ff, state_in;
   logic [13:0] bin_ff, bin_in;
   logic [15:0] bcd_ff, bcd_in;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  idx_ff, idx_in;

   logic [1:0]  op;
   logic [13:0] num;
   logic [7:0]  ch;
   logic [1:0]  pos;
   logic        accept;
   logic [15:0] bcd_adj;
   logic [1:0]  nib_sel;
   logic [3:0]  digit;
   logic [7:0]  segs;

   assign op  = req_tdata[1:0];
   assign num = req_tdata[15:2];
   assign ch  = req_tdata[23:16];
   assign pos = req_tdata[25:24];

   assign req_tready = (state_ff == ST_IDLE) && !queue_full;
   assign accept     = req_tvalid && req_tready;

   // thousands digit sits in the top nibble
   assign nib_sel = 2'd3 - idx_ff;
   assign digit   = bcd_ff[{nib_sel, 2'b00} +: 4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                         : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      segs     = BLANK_SEGMENTS;
      push     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_NUMBER: begin
                     if (num <= NUMBER_MAX) begin
                        bin_in   = num;
                        bcd_in   = '0;
                        step_in  = '0;
                        state_in = ST_CONVERT;
                     end
                  end
                  OP_CHARACTER, OP_BLANK: begin
                     if ({1'b0, pos} < 3'(DIGIT_COUNT)) begin
                        segs       = (op == OP_CHARACTER) ? letter_segments(ch)
                                                          : BLANK_SEGMENTS;
                        push.valid = 1'b1;
                        push.frame = {segs, select_pattern(pos)};
                        push.last  = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CONVERT: begin
            // one double-dabble step per cycle
            bcd_in  = {bcd_adj[14:0], bin_ff[13]};
            bin_in  = {bin_ff[12:0], 1'b0};
            step_in = step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               idx_in   = '0;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!queue_full) begin
               push.valid = 1'b1;
               push.frame = {digit_segments(digit), select_pattern(idx_ff)};
               push.last  = (idx_ff == LAST_IDX);
               idx_in     = idx_ff + 2'd1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
   end

endmodule

// ===== hdl/ssd_queue.sv =====
// four-entry frame queue between the decoder and the shifter
// depends on ssd_pkg and seven_segment_serial_driver_defines.svh
`include "seven_segment_serial_driver_defines.svh"
module ssd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ssd_pkg::ssd_entry_type push,
   output logic                   full,
   output ssd_pkg::ssd_entry_type head,
   input  logic                   pop
);
   import ssd_pkg::*;

   logic [FRAME_BITS:0] store_ff [QUEUE_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_push;

   assign full    = (count_ff == 3'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;

   assign head.valid = (count_ff != 3'd0);
   assign head.frame = store_ff[rd_ptr_ff][FRAME_BITS:1];
   assign head.last  = store_ff[rd_ptr_ff][0];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !pop) begin
         count_in = count_ff + 3'd1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= {push.frame, push.last};
      end
   end

   `SSD_ASSERT_SAME(a_push_not_full, push.valid, !full, "frame pushed into full queue")
   `SSD_ASSERT_SAME(a_pop_not_empty, pop, head.valid, "pop from empty queue")
   `SSD_ASSERT_SAME(a_count_range, 1'b1, count_ff <= 3'(QUEUE_DEPTH), "queue count overflow")
   `SSD_ASSERT_NEXT(a_count_up, do_push && !pop, count_ff == $past(count_ff) + 3'd1,
                    "queue count did not advance on push")

endmodule

// ===== hdl/ssd_back.sv =====
// frame shifter: sends each queued frame msb first, one bit per beat
// depends on ssd_pkg
module ssd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ssd_pkg::ssd_entry_type head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,  // serial_bit, zero pad
   output logic                   rsp_tuser,  // latch_after
   output logic                   rsp_tlast
);
   import ssd_pkg::*;

   localparam logic [3:0] LAST_BIT = 4'(FRAME_BITS - 1);

   logic                  active_ff, active_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic                  last_ff, last_in;
   logic                  fire;
   logic                  end_bit;

   assign end_bit = (cnt_ff == LAST_BIT);
   assign fire    = active_ff && rsp_tready;
   // next frame loads straight behind the last bit of the current one
   assign pop     = head.valid && (!active_ff || (fire && end_bit));

   assign rsp_tvalid = active_ff;
   assign rsp_tdata  = {7'd0, shift_ff[FRAME_BITS-1]};
   assign rsp_tuser  = end_bit;
   assign rsp_tlast  = end_bit && last_ff;

   always_comb begin
      active_in = active_ff;
      shift_in  = shift_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      if (pop) begin
         active_in = 1'b1;
         shift_in  = head.frame;
         cnt_in    = '0;
         last_in   = head.last;
      end else if (fire) begin
         if (end_bit) begin
            active_in = 1'b0;
            cnt_in    = '0;
         end else begin
            shift_in = {shift_ff[FRAME_BITS-2:0], 1'b0};
            cnt_in   = cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
      shift_ff <= shift_in;
      last_ff  <= last_in;
   end

endmodule

// ===== sim/ssd_checker.sv =====
// checker for the seven-segment serial driver: predicts the serial bit beats of
// each accepted request and compares them with the response channel
// depends on ssd_pkg for operation codes and limits
module ssd_checker #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          bits_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import ssd_pkg::*;

   typedef struct packed {
      logic serial_bit;
      logic latch_after;
      logic last;
   } serial_beat_type;

   // segment tables, entry 0 in the lowest byte
   localparam logic [79:0] DIGIT_SEGS = {
      8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
   };
   localparam logic [207:0] LETTER_SEGS = {
      8'hA4, 8'h91, 8'h89, 8'hD5, 8'hC1, 8'hC1, 8'h87, 8'h92, 8'hCC, 8'h4A,
      8'h8C, 8'hC0, 8'hC8, 8'hEA, 8'hC7, 8'h8A, 8'hE1, 8'hCF, 8'h89, 8'hC2,
      8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88
   };
   localparam logic [31:0] DIGIT_SELECTS = {8'hF8, 8'hF4, 8'hF2, 8'hF1};

   serial_beat_type expected_bits[$];

   function automatic void queue_frame(logic [15:0] frame, bit final_frame);
      for (int b = 0; b < FRAME_BITS; b++) begin
         expected_bits.push_back('{serial_bit: frame[15 - b],
                                   latch_after: (b == FRAME_BITS - 1),
                                   last: (final_frame && b == FRAME_BITS - 1)});
      end
   endfunction

   function automatic void predict_display(logic [31:0] data);
      logic [1:0]  op;
      logic [13:0] num;
      logic [7:0]  ch;
      logic [1:0]  pos;
      logic [7:0]  segs;
      int          frames;
      int          divisor;
      int          digit;
      op  = data[1:0];
      num = data[15:2];
      ch  = data[23:16];
      pos = data[25:24];
      case (op)
         OP_NUMBER: begin
            if (num <= NUMBER_MAX) begin
               frames  = (DIGIT_COUNT < 4) ? DIGIT_COUNT : 4;
               divisor = 1000;
               for (int f = 0; f < frames; f++) begin
                  digit = (int'(num) / divisor) % 10;
                  queue_frame({DIGIT_SEGS[digit*8 +: 8], DIGIT_SELECTS[f*8 +: 8]},
                              f == frames - 1);
                  divisor = divisor / 10;
               end
            end
         end
         OP_CHARACTER, OP_BLANK: begin
            if (int'(pos) < DIGIT_COUNT) begin
               segs = BLANK_SEGMENTS;
               if (op == OP_CHARACTER) begin
                  // fold lower case onto upper case, anything else stays blank
                  if (ch >= 8'h61 && ch <= 8'h7A) begin
                     ch = ch - 8'd32;
                  end
                  if (ch >= 8'h41 && ch <= 8'h5A) begin
                     segs = LETTER_SEGS[(int'(ch) - 'h41)*8 +: 8];
                  end
               end
               queue_frame({segs, DIGIT_SELECTS[int'(pos)*8 +: 8]}, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      serial_beat_type exp_beat;
      if (reset) begin
         expected_bits.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_display(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bits.size() == 0) begin
               $error("unexpected response beat: bit %0b latch %0b last %0b",
                      rsp_tdata[0], rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               exp_beat = expected_bits.pop_front();
               if (rsp_tdata[0] !== exp_beat.serial_bit) begin
                  $error("serial_bit: expected %0b, got %0b",
                         exp_beat.serial_bit, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tuser !== exp_beat.latch_after) begin
                  $error("latch_after: expected %0b, got %0b",
                         exp_beat.latch_after, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== exp_beat.last) begin
                  $error("last: expected %0b, got %0b", exp_beat.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      bits_outstanding = expected_bits.size();
   end

endmodule

// ===== sim/tb.sv =====
// top of the seven-segment serial driver testbench: clock, reset, request
// stimulus and response back-pressure; checking is done in ssd_checker
// depends on ssd_pkg, ssd_checker and seven_segment_serial_driver
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssd_pkg::*;

   localparam int         DIGITS        = 4;
   localparam logic [1:0] OP_RESERVED   = 2'd3;
   localparam int         ITEM_TARGET   = 300;
   localparam int         QUIET_ITEMS   = 40;
   localparam int         LONG_HOLD     = 300;
   localparam int         SETTLE_CYCLES = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int bits_outstanding;
   bit quiet        = 1'b0;
   bit hold_request = 1'b0;
   int no_gap_left  = 0;
   int useful_sent  = 0;

   always #5 clock = ~clock;

   seven_segment_serial_driver #(.DIGIT_COUNT(DIGITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ssd_checker #(.DIGIT_COUNT(DIGITS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .fail_count       (fail_count),
      .bits_outstanding (bits_outstanding)
   );

   function automatic logic [31:0] pack_request(logic [1:0] op, logic [13:0] num,
                                                logic [7:0] ch, logic [1:0] pos);
      return {6'd0, pos, ch, num, op};
   endfunction

   // one request beat, optionally preceded by an idle burst; valid stays high after
   task automatic offer(logic [31:0] data);
      int gap;
      if (!quiet && no_gap_left == 0 && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (no_gap_left > 0) begin
         no_gap_left--;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_pause();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (bits_outstanding != 0) @(negedge clock);
   endtask

   task automatic offer_random();
      logic [1:0]  op;
      logic [13:0] num;
      logic [7:0]  ch;
      logic [1:0]  pos;
      int          sel;
      sel = $urandom_range(0, 99);
      num = $urandom_range(0, 16383);
      ch  = $urandom_range(0, 255);
      pos = $urandom_range(0, 3);
      if (sel < 45) begin
         op = OP_NUMBER;
         if ($urandom_range(0, 9) != 0) begin
            num = $urandom_range(0, NUMBER_MAX);
         end
      end else if (sel < 80) begin
         op = OP_CHARACTER;
         case ($urandom_range(0, 2))
            0:       ch = $urandom_range(8'h41, 8'h5A);
            1:       ch = $urandom_range(8'h61, 8'h7A);
            default: ;
         endcase
      end else if (sel < 95) begin
         op = OP_BLANK;
      end else begin
         op = OP_RESERVED;
      end
      offer(pack_request(op, num, ch, pos));
      if (op == OP_CHARACTER || op == OP_BLANK || (op == OP_NUMBER && num <= NUMBER_MAX))
      begin
         useful_sent++;
         if (useful_sent == 100) begin
            // stall the sink for a long stretch while requests keep coming
            hold_request = 1'b1;
            no_gap_left  = 12;
         end
         if (useful_sent == 200) begin
            drain_pause();
         end
         quiet = (useful_sent >= ITEM_TARGET - QUIET_ITEMS);
      end
   endtask

   // response back-pressure
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // every digit value, range edges, letter boundaries, blanks and ignored codes
      offer(pack_request(OP_NUMBER, 14'd0, 8'h00, 2'd0));
      offer(pack_request(OP_NUMBER, NUMBER_MAX, 8'hFF, 2'd3));
      offer(pack_request(OP_NUMBER, 14'd1234, 8'h5A, 2'd1));
      offer(pack_request(OP_NUMBER, 14'd5678, 8'h61, 2'd2));
      offer(pack_request(OP_NUMBER, 14'd10000, 8'h41, 2'd0));
      offer(pack_request(OP_NUMBER, 14'd16383, 8'hFF, 2'd3));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h41, 2'd0));
      offer(pack_request(OP_CHARACTER, 14'd16383, 8'h5A, 2'd1));
      offer(pack_request(OP_CHARACTER, 14'd9999, 8'h61, 2'd2));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h7A, 2'd3));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h71, 2'd1));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h40, 2'd2));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h5B, 2'd3));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h60, 2'd0));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h7B, 2'd1));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h00, 2'd2));
      offer(pack_request(OP_CHARACTER, 14'd0, 8'h80, 2'd3));
      offer(pack_request(OP_CHARACTER, 14'd16383, 8'hFF, 2'd0));
      offer(pack_request(OP_BLANK, 14'd0, 8'h00, 2'd0));
      offer(pack_request(OP_BLANK, 14'd16383, 8'hFF, 2'd1));
      offer(pack_request(OP_BLANK, 14'd5, 8'h41, 2'd2));
      offer(pack_request(OP_BLANK, 14'd9999, 8'h7A, 2'd3));
      offer(pack_request(OP_RESERVED, 14'd16383, 8'hFF, 2'd3));
      offer(pack_request(OP_RESERVED, 14'd0, 8'h41, 2'd0));
      useful_sent = 20;

      while (useful_sent < ITEM_TARGET) begin
         offer_random();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (bits_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ssd_pkg.sv
hdl/ssd_front.sv
hdl/ssd_queue.sv
hdl/ssd_back.sv
hdl/seven_segment_serial_driver.sv
sim/ssd_checker.sv
sim/tb.sv
